// ----- rtl/dts_pkg.sv -----
package dts_pkg;

  localparam int MAX_TASKS = 8;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = 4;
  localparam int WORK_W    = 16;
  localparam int TIME_W    = 32;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [CNT_W-1:0] TASK_COUNT_RESET = CNT_W'(1);
  localparam logic [WORK_W-1:0] WORK_MAX = '1;

  typedef struct packed {
    logic        command;
    logic [2:0]  task_index;
    logic [15:0] exec_time;
    logic [15:0] period;
    logic [15:0] rel_deadline;
  } in_t;

  typedef struct packed {
    logic [31:0] tick_time;
    logic        busy_res;
    logic [3:0]  task_id;
    logic [15:0] task_deadline;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } dp_stat_t;

endpackage

// ----- rtl/dts_ctrl.sv -----
module dts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              command,
  output logic              in_ready,
  input  dts_pkg::dp_stat_t stat,
  output dts_pkg::dp_cmd_t  cmd
);

  dts_pkg::state_t state;
  dts_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      dts_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (command == dts_pkg::CMD_TICK) begin
            cmd.start  = 1'b1;
            state_next = dts_pkg::ST_SCAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      dts_pkg::ST_SCAN: begin
        cmd.step = 1'b1;
        if (stat.scan_last) begin
          state_next = dts_pkg::ST_COMMIT;
        end
      end
      dts_pkg::ST_COMMIT: begin
        if (!stat.out_busy) begin
          cmd.commit = 1'b1;
          state_next = dts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dts_pkg::ST_IDLE;
      end
    endcase
  end

  a_scan_to_commit: assert property (@(posedge clk) disable iff (rst)
    (state == dts_pkg::ST_SCAN && stat.scan_last) |=> state == dts_pkg::ST_COMMIT)
    else $error("scan end did not reach commit");

endmodule

// ----- rtl/dts_dp.sv -----
module dts_dp (
  input  logic              clk,
  input  logic              rst,
  input  dts_pkg::in_t      in_data,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_wdata,
  input  dts_pkg::dp_cmd_t  cmd,
  output dts_pkg::dp_stat_t stat,
  output logic              out_valid,
  input  logic              out_ready,
  output dts_pkg::out_t     out_data
);

  logic [dts_pkg::WORK_W-1:0] exec_table     [dts_pkg::MAX_TASKS];
  logic [dts_pkg::WORK_W-1:0] period_table   [dts_pkg::MAX_TASKS];
  logic [dts_pkg::WORK_W-1:0] deadline_table [dts_pkg::MAX_TASKS];
  logic [dts_pkg::WORK_W-1:0] pending_work   [dts_pkg::MAX_TASKS];
  logic [dts_pkg::TIME_W-1:0] release_time   [dts_pkg::MAX_TASKS];

  logic [dts_pkg::TIME_W-1:0] now;
  logic [dts_pkg::CNT_W-1:0]  task_count;
  logic [dts_pkg::IDX_W-1:0]  idx;
  logic                       found;
  logic [dts_pkg::IDX_W-1:0]  sel;
  logic [dts_pkg::WORK_W-1:0] best;

  logic [dts_pkg::CNT_W-1:0]  n_active;
  logic                       slot_active;
  logic                       slot_release;
  logic [dts_pkg::WORK_W:0]   work_sum;
  logic [dts_pkg::WORK_W-1:0] work_next;
  logic                       slot_better;
  logic                       out_busy;

  assign n_active = (task_count > dts_pkg::CNT_W'(dts_pkg::MAX_TASKS))
                    ? dts_pkg::CNT_W'(dts_pkg::MAX_TASKS) : task_count;
  assign slot_active  = dts_pkg::CNT_W'(idx) < n_active;
  assign slot_release = slot_active && (release_time[idx] == now);
  assign work_sum     = {1'b0, pending_work[idx]} + {1'b0, exec_table[idx]};
  assign work_next    = slot_release
                        ? (work_sum[dts_pkg::WORK_W] ? dts_pkg::WORK_MAX
                                                     : work_sum[dts_pkg::WORK_W-1:0])
                        : pending_work[idx];
  assign slot_better  = slot_active && (work_next != '0)
                        && (!found || deadline_table[idx] < best);

  assign out_busy       = out_valid && !out_ready;
  assign stat.out_busy  = out_busy;
  assign stat.scan_last = (idx == dts_pkg::IDX_W'(dts_pkg::MAX_TASKS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= dts_pkg::TASK_COUNT_RESET;
    end else if (cfg_we) begin
      task_count <= cfg_wdata;
    end
  end

  // task tables
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      exec_table[in_data.task_index]     <= in_data.exec_time;
      period_table[in_data.task_index]   <= in_data.period;
      deadline_table[in_data.task_index] <= in_data.rel_deadline;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dts_pkg::MAX_TASKS; i++) begin
        pending_work[i] <= '0;
        release_time[i] <= '0;
      end
    end else if (cmd.load) begin
      pending_work[in_data.task_index] <= '0;
      release_time[in_data.task_index] <= '0;
    end else if (cmd.step) begin
      pending_work[idx] <= work_next;
      if (slot_release) begin
        release_time[idx] <= release_time[idx]
                             + dts_pkg::TIME_W'(period_table[idx]);
      end
    end else if (cmd.commit && found) begin
      pending_work[sel] <= pending_work[sel] - dts_pkg::WORK_W'(1);
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      found <= 1'b0;
    end else if (cmd.start) begin
      idx   <= '0;
      found <= 1'b0;
    end else if (cmd.step) begin
      idx <= idx + dts_pkg::IDX_W'(1);
      if (slot_better) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && slot_better) begin
      sel  <= idx;
      best <= deadline_table[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now <= '0;
    end else if (cmd.commit) begin
      now <= now + dts_pkg::TIME_W'(1);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data.tick_time <= now;
      out_data.busy_res  <= found;
      if (found) begin
        out_data.task_id       <= 4'({1'b0, sel}) + 4'd1;
        out_data.task_deadline <= best;
      end else begin
        out_data.task_id       <= '0;
        out_data.task_deadline <= '0;
      end
    end
  end

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !out_busy)
    else $error("commit over an untaken word");

  a_commit_word: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid && out_data.tick_time == $past(now)
                   && now == $past(now) + dts_pkg::TIME_W'(1))
    else $error("committed word or time mismatch");

  a_busy_id: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.busy_res) |-> out_data.task_id != 4'd0)
    else $error("busy word without a task");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.busy_res)
      |-> (out_data.task_id == 4'd0 && out_data.task_deadline == '0))
    else $error("idle word carries task fields");

endmodule

// ----- rtl/deadline_tick_scheduler.sv -----
// Periodic task scheduler with static deadline priority, one word per time
// tick. A load word (command 0) gives no result. A tick word (command 1)
// runs a pass that walks the task slots, releasing due tasks and keeping
// the best pending one, then commits the result into the output register.
// A new word is taken once the pass has committed, even while the result
// still waits in the output register; a tick's commit waits only for that
// register to free. task_count is written through cfg_we and cfg_wdata.
module deadline_tick_scheduler (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  dts_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dts_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [3:0]    cfg_wdata
);

  dts_pkg::dp_cmd_t  cmd;
  dts_pkg::dp_stat_t stat;

  dts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (in_data.command),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dts_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- tb/sv/deadline_tick_scheduler_test.sv -----
module deadline_tick_scheduler_test;
  import dts_pkg::*;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_we;
  logic [3:0] cfg_wdata;

  deadline_tick_scheduler DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // scheduler shadow state
  logic [15:0] exec_tab [MAX_TASKS];
  logic [15:0] period_tab [MAX_TASKS];
  logic [15:0] dl_tab [MAX_TASKS];
  logic [15:0] pend [MAX_TASKS];
  logic [31:0] rel_at [MAX_TASKS];
  logic [31:0] now_tick;
  logic [3:0] task_cnt;

  out_t tick_reports [$];
  int mismatch_count;
  int src_gap_max;
  int sink_gap_max;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

  task automatic schedule_word(input in_t w);
    int n;
    int sel;
    logic [16:0] sum;
    out_t rep;
    if (w.command == CMD_LOAD) begin
      exec_tab[w.task_index] = w.exec_time;
      period_tab[w.task_index] = w.period;
      dl_tab[w.task_index] = w.rel_deadline;
      pend[w.task_index] = '0;
      rel_at[w.task_index] = '0;
      return;
    end
    n = (task_cnt > MAX_TASKS) ? MAX_TASKS : task_cnt;
    // release due tasks
    for (int i = 0; i < n; i++) begin
      if (rel_at[i] == now_tick) begin
        sum = pend[i] + exec_tab[i];
        pend[i] = sum[16] ? WORK_MAX : sum[15:0];
        rel_at[i] = rel_at[i] + period_tab[i];
      end
    end
    // lowest static deadline, lowest index on ties
    sel = -1;
    for (int i = 0; i < n; i++) begin
      if (pend[i] != 0 && (sel < 0 || dl_tab[i] < dl_tab[sel])) sel = i;
    end
    rep.tick_time = now_tick;
    if (sel >= 0) begin
      pend[sel] = pend[sel] - 1'b1;
      rep.busy_res = 1'b1;
      rep.task_id = 4'(sel + 1);
      rep.task_deadline = dl_tab[sel];
    end else begin
      rep.busy_res = 1'b0;
      rep.task_id = '0;
      rep.task_deadline = '0;
    end
    tick_reports.push_back(rep);
    now_tick = now_tick + 1;
  endtask

  function automatic in_t load_word(input int slot, input int e, input int p, input int d);
    in_t w;
    w.command = CMD_LOAD;
    w.task_index = 3'(slot);
    w.exec_time = 16'(e);
    w.period = 16'(p);
    w.rel_deadline = 16'(d);
    return w;
  endfunction

  function automatic in_t tick_word();
    logic [63:0] r;
    in_t w;
    r = {$urandom, $urandom};
    w = r[$bits(in_t)-1:0];
    w.command = CMD_TICK;
    return w;
  endfunction

  task automatic send_word(input in_t w);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    schedule_word(w);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tick_reports.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_task_count(input logic [3:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    task_cnt = v;
  endtask

  task automatic test_count_above_max();
    set_task_count(4'd15);
    send_word(load_word(0, 1, 4, 10));
    send_word(load_word(1, 2, 7, 3));
    send_word(load_word(2, 0, 1, 0));
    send_word(load_word(3, 3, 0, 5));
    send_word(load_word(4, 1, 5, 3));
    send_word(load_word(5, 2, 65535, 20));
    send_word(load_word(6, 2, 6, 0));
    send_word(load_word(7, 65535, 1, 65535));
    repeat (12) send_word(tick_word());
  endtask

  task automatic test_late_load();
    // release stays at zero, so this task never runs again
    send_word(load_word(2, 5, 1, 0));
    repeat (4) send_word(tick_word());
  endtask

  task automatic test_random_schedule();
    int slot;
    in_t w;
    for (int c = 8; c >= 1; c--) begin
      settle();
      set_task_count(4'(c));
      src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
      sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
      for (int k = 0; k < 230; k++) begin
        if ($urandom_range(0, 99) < 6) begin
          if (c < MAX_TASKS && $urandom_range(0, 4) != 0) slot = $urandom_range(c, 7);
          else slot = $urandom_range(0, 7);
          w = load_word(slot, $urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535));
          send_word(w);
        end else begin
          send_word(tick_word());
        end
      end
    end
  endtask

  task automatic test_count_zero();
    settle();
    set_task_count(4'd0);
    src_gap_max = 4;
    sink_gap_max = 4;
    repeat (10) send_word(tick_word());
    send_word(load_word(0, 1, 1, 1));
    repeat (10) send_word(tick_word());
  endtask

  function automatic void compare_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (out_valid && out_ready) begin
      if (tick_reports.size() == 0) begin
        $error("result word with no tick outstanding: tick_time %0d", out_data.tick_time);
        mismatch_count++;
      end else begin
        want = tick_reports.pop_front();
        compare_field("tick_time", want.tick_time, out_data.tick_time);
        compare_field("busy_res", want.busy_res, out_data.busy_res);
        compare_field("task_id", want.task_id, out_data.task_id);
        compare_field("task_deadline", want.task_deadline, out_data.task_deadline);
      end
    end
  end

  // result side stalls
  initial begin
    int stall;
    stall = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        stall = $urandom_range(0, sink_gap_max);
        if (stall != 0) out_ready <= 1'b0;
      end else if (!out_ready) begin
        stall--;
        if (stall <= 0) out_ready <= 1'b1;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    foreach (exec_tab[i]) begin
      exec_tab[i] = '0;
      period_tab[i] = '0;
      dl_tab[i] = '0;
      pend[i] = '0;
      rel_at[i] = '0;
    end
    now_tick = '0;
    task_cnt = TASK_COUNT_RESET;
    mismatch_count = 0;
    src_gap_max = 4;
    sink_gap_max = 4;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_count_above_max();
    test_late_load();
    test_random_schedule();
    test_count_zero();
    settle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- deadline_tick_scheduler.f -----
rtl/dts_pkg.sv
rtl/dts_ctrl.sv
rtl/dts_dp.sv
rtl/deadline_tick_scheduler.sv
tb/sv/deadline_tick_scheduler_test.sv
